/* rtl/mat_pkg.sv */
// Package for the multicast address table.
// Holds the operation codes, field widths, controller states and the
// command and status words shared by the controller and the datapath.
package mat_pkg;

  localparam int MAC_BYTES = 6;
  localparam int MAC_W     = MAC_BYTES * 8;
  localparam int CFG_W     = 5;
  localparam int COUNT_W   = 5;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 5'd16;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic set_fail;
    logic append;
    logic shift_init;
    logic shift;
    logic shrink;
  } cmd_t;

  typedef struct packed {
    logic full_add;
    logic is_del;
    logic match;
    logic miss;
    logic shift_end;
  } sts_t;

endpackage

/* rtl/mat_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the address store of the multicast address table.
module mat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mat_ctrl.sv */
// Controller of the multicast address table: request sequencing FSM.
// Depends on mat_pkg for the state encoding and the command/status words.
module mat_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mat_pkg::sts_t sts,
  output logic          busy,
  output logic          out_valid,
  output mat_pkg::cmd_t cmd
);

  import mat_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.full_add ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.match) begin
          if (sts.is_del) begin
            cmd.shift_init = 1'b1;
            state_nxt      = ST_SHIFT;
          end else begin
            cmd.set_fail = 1'b1;
            state_nxt    = ST_RESP;
          end
        end else if (sts.miss) begin
          if (sts.is_del) begin
            cmd.set_fail = 1'b1;
          end else begin
            cmd.append = 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_end) begin
          cmd.shrink = 1'b1;
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);

endmodule

/* rtl/mat_dp.sv */
// Datapath of the multicast address table: limit register, count, scan and
// shift pointers, address store. Depends on mat_pkg and mat_ram.
module mat_dp #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mat_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        in_func,
  input  logic [mat_pkg::MAC_W-1:0]   in_mac_address,
  input  mat_pkg::cmd_t               cmd,
  output mat_pkg::sts_t               sts,
  output logic                        out_failed,
  output logic [mat_pkg::COUNT_W-1:0] out_entry_count
);

  import mat_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] max_entries_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic             fail_r, fail_nxt;
  logic             func_r;
  logic [MAC_W-1:0] addr_r;

  logic             full;
  logic             more;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [MAC_W-1:0] ram_wdata;
  logic [MAC_W-1:0] ram_q;
  logic [CNT_W-1:0] dst_idx;

  mat_ram #(
    .WIDTH (MAC_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr_r[AW-1:0]),
    .rdata (ram_q)
  );

  assign full = (LW'(count_r) >= LW'(max_entries_r)) || (count_r >= CNT_W'(DEPTH));
  assign more = (rd_ptr_r < count_r);

  assign sts.full_add  = (in_func == FUNC_ADD) && full;
  assign sts.is_del    = (func_r == FUNC_DEL);
  assign sts.match     = cmp_vld_r && (ram_q == addr_r);
  assign sts.miss      = !cmp_vld_r && !more;
  assign sts.shift_end = !cmp_vld_r && !more;

  assign dst_idx   = cmp_idx_r - CNT_W'(1);
  assign ram_we    = cmd.append || (cmd.shift && cmp_vld_r);
  assign ram_waddr = cmd.append ? count_r[AW-1:0] : dst_idx[AW-1:0];
  assign ram_wdata = cmd.append ? addr_r : ram_q;

  always_comb begin
    count_nxt   = count_r;
    rd_ptr_nxt  = rd_ptr_r;
    cmp_idx_nxt = cmp_idx_r;
    cmp_vld_nxt = cmp_vld_r;
    fail_nxt    = fail_r;
    if (cmd.load) begin
      rd_ptr_nxt  = '0;
      cmp_vld_nxt = 1'b0;
      fail_nxt    = sts.full_add;
    end
    if (cmd.scan || cmd.shift) begin
      cmp_idx_nxt = rd_ptr_r;
      cmp_vld_nxt = more;
      if (more) begin
        rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
      end
    end
    if (cmd.shift_init) begin
      rd_ptr_nxt  = cmp_idx_r + CNT_W'(1);
      cmp_vld_nxt = 1'b0;
      fail_nxt    = 1'b0;
    end
    if (cmd.set_fail) begin
      fail_nxt = 1'b1;
    end
    if (cmd.append) begin
      count_nxt = count_r + CNT_W'(1);
      fail_nxt  = 1'b0;
    end
    if (cmd.shrink) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RST;
      count_r       <= '0;
      rd_ptr_r      <= '0;
      cmp_idx_r     <= '0;
      cmp_vld_r     <= 1'b0;
      fail_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
      count_r   <= count_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      cmp_idx_r <= cmp_idx_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      fail_r    <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      addr_r <= in_mac_address;
    end
  end

  assign out_failed      = fail_r;
  assign out_entry_count = COUNT_W'(count_r);

endmodule

/* rtl/multicast_address_table.sv */
// Multicast address table, top level: dense list of 48-bit addresses.
// Joins mat_ctrl and mat_dp; depends on mat_pkg.
//
// Usage:
//   A request (in_func: add or delete, in_mac_address) is taken at a rising
//   edge with start high and busy low. busy stays high until the result has
//   been shown. The result (out_failed, out_entry_count) is on the out_
//   ports for one cycle, marked by out_valid; the receiver cannot stall it.
//   The next request is taken from the cycle after out_valid.
//   An add to a full list goes straight to the result; any other request
//   first scans the list, and a delete that hits then also shifts the later
//   entries down one place.
//   The address store is a RAM read one entry per cycle; the scan and the
//   shift-down of later entries after a delete each walk it at most once.
//   cfg_we / cfg_wdata write the largest count allowed (reset 16); the
//   limit in force is the smaller of it and DEPTH. Write it while idle.
//   Reset (rst_n low, synchronous) empties the list and returns to idle;
//   no clearing pass is needed.
module multicast_address_table #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [mat_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [mat_pkg::MAC_W-1:0]   in_mac_address,
  output logic                        out_valid,
  output logic                        out_failed,
  output logic [mat_pkg::COUNT_W-1:0] out_entry_count
);

  import mat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mat_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_mac_address  (in_mac_address),
    .cmd             (cmd),
    .sts             (sts),
    .out_failed      (out_failed),
    .out_entry_count (out_entry_count)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_valid_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_valid_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!busy && !out_valid))
    else $error("block not released after result");

  a_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.shift}))
    else $error("overlapping controller phases");

endmodule
